// ----- design/bss_pkg.sv -----
// bss_pkg: shared types and codes for the bounded stack with search
// operation codes, status codes and the controller state type
// no dependencies
package bss_pkg;

  localparam int DATA_W = 32;
  localparam int OUT_W  = 7;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH
  } state_t;

endpackage

// ----- design/bss_ram.sv -----
// bss_ram: stack storage with one write port and one read port, one write and one read per cycle
// read data registered
// depends on bss_pkg
module bss_ram #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic [bss_pkg::DATA_W-1:0]          wr_data,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic [bss_pkg::DATA_W-1:0]          rd_data
);
  import bss_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/bounded_stack_with_search_core.sv -----
// bounded_stack_with_search_core: LIFO stack of 32-bit values with search from top
// controller and result register around the bss_ram storage
// depends on bss_pkg and bss_ram
//
// Input channel (in_valid/in_ready) carries one operation per beat: push, pop
// or search from top, with a 32-bit value. Output channel (out_valid/out_ready)
// returns exactly one result beat per input beat: status, data, 1-based match
// position and the fill level after the operation.
// Path from input beat to result: push, full push, the unused code and a pop or search on
// an empty stack are answered from the idle state; other pops pass through the pop state
// for one storage read; a search passes through the search state, visiting entries from
// the top until a match or until all level entries are visited. The walk reads one entry
// a cycle through the single read port, which sets the search time.
// One operation is in flight at a time; a new beat is taken in the cycle its
// predecessor's result is taken, or at once if the result register is empty.
// Reset clears the state, the fill level and the result valid flag; the storage needs no
// clearing since only entries below the level are ever read.
// A stalled receiver holds the result register and, with it, the input.
module bounded_stack_with_search_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic signed [31:0]   value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic signed [31:0]   data,
  output logic [6:0]           position,
  output logic [6:0]           level
);
  import bss_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t              state, state_next;
  logic [CW-1:0]       fill, fill_next;
  logic [CW-1:0]       pos, pos_next;
  logic [AW-1:0]       walk_addr, walk_addr_next;
  logic [DATA_W-1:0]   key, key_next;

  logic                out_valid_next;
  logic [1:0]          status_next;
  logic [DATA_W-1:0]   data_next;
  logic [OUT_W-1:0]    position_next;
  logic [OUT_W-1:0]    level_next;

  logic                accept;
  logic                full;
  logic                empty;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [DATA_W-1:0]   rd_data;

  bss_ram #(
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign full     = (fill == CW'(STACK_DEPTH));
  assign empty    = (fill == '0);
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign wr_addr  = AW'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    walk_addr <= walk_addr_next;
    key       <= key_next;
    status    <= status_next;
    data      <= data_next;
    position  <= position_next;
    level     <= level_next;
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    pos_next       = pos;
    walk_addr_next = walk_addr;
    key_next       = key;
    out_valid_next = out_valid && !out_ready;
    status_next    = status;
    data_next      = data;
    position_next  = position;
    level_next     = level;
    wr_en          = 1'b0;
    // next entry down from the current walk position
    rd_addr        = walk_addr - 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_PUSH: begin
              out_valid_next = 1'b1;
              data_next      = '0;
              position_next  = '0;
              if (full) begin
                status_next = ST_OVERFLOW;
                level_next  = OUT_W'(fill);
              end else begin
                wr_en       = 1'b1;
                fill_next   = CW'(fill + 1'b1);
                status_next = ST_OK;
                level_next  = OUT_W'(CW'(fill + 1'b1));
              end
            end
            OP_POP: begin
              if (empty) begin
                out_valid_next = 1'b1;
                status_next    = ST_EMPTY;
                data_next      = '0;
                position_next  = '0;
                level_next     = OUT_W'(fill);
              end else begin
                fill_next  = CW'(fill - 1'b1);
                rd_addr    = AW'(fill - 1'b1);
                state_next = S_POP;
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                out_valid_next = 1'b1;
                status_next    = ST_EMPTY;
                data_next      = '0;
                position_next  = '0;
                level_next     = OUT_W'(fill);
              end else begin
                rd_addr        = AW'(fill - 1'b1);
                walk_addr_next = AW'(fill - 1'b1);
                pos_next       = CW'(1);
                key_next       = value;
                state_next     = S_SEARCH;
              end
            end
            default: begin
              out_valid_next = 1'b1;
              status_next    = ST_OK;
              data_next      = '0;
              position_next  = '0;
              level_next     = OUT_W'(fill);
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_next = 1'b1;
        status_next    = ST_OK;
        data_next      = rd_data;
        position_next  = '0;
        level_next     = OUT_W'(fill);
        state_next     = S_IDLE;
      end
      S_SEARCH: begin
        // rd_data holds the entry at position pos from the top
        if (rd_data == key) begin
          out_valid_next = 1'b1;
          status_next    = ST_OK;
          data_next      = key;
          position_next  = OUT_W'(pos);
          level_next     = OUT_W'(fill);
          state_next     = S_IDLE;
        end else if (pos == fill) begin
          out_valid_next = 1'b1;
          status_next    = ST_NOT_FOUND;
          data_next      = '0;
          position_next  = '0;
          level_next     = OUT_W'(fill);
          state_next     = S_IDLE;
        end else begin
          pos_next       = CW'(pos + 1'b1);
          walk_addr_next = walk_addr - 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- tb/tb_bounded_stack_with_search_core.sv -----
// tb_bounded_stack_with_search_core: self-checking testbench for the bounded stack with search
// directed table then phased random push/pop/search traffic, checked against a stack predictor
// depends on bss_pkg and bounded_stack_with_search_core
`timescale 1ns / 100ps

module tb_bounded_stack_with_search_core;
  import bss_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int RANDOM_BEATS = 1707;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [6:0]         position;
    logic [6:0]         level;
  } stack_result_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] val;
    logic [7:0]         reps;
    logic               typed;
    stack_result_t      res;
  } dir_row_t;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_t;

  // rows with typed = 0 are checked against the predictor
  localparam dir_row_t DIRECTED [22] = '{
    '{OP_POP,    32'sd0,           8'd1,  1'b1, '{ST_EMPTY,     32'sd0,           7'd0,  7'd0}},
    '{OP_SEARCH, 32'sd5,           8'd1,  1'b1, '{ST_EMPTY,     32'sd0,           7'd0,  7'd0}},
    '{OP_UNUSED, -32'sd1,          8'd1,  1'b1, '{ST_OK,        32'sd0,           7'd0,  7'd0}},
    '{OP_PUSH,   32'sh7fffffff,    8'd1,  1'b1, '{ST_OK,        32'sd0,           7'd0,  7'd1}},
    '{OP_PUSH,   32'sh80000000,    8'd1,  1'b1, '{ST_OK,        32'sd0,           7'd0,  7'd2}},
    '{OP_PUSH,   32'sd0,           8'd1,  1'b1, '{ST_OK,        32'sd0,           7'd0,  7'd3}},
    '{OP_PUSH,   -32'sd1,          8'd1,  1'b1, '{ST_OK,        32'sd0,           7'd0,  7'd4}},
    '{OP_SEARCH, 32'sh7fffffff,    8'd1,  1'b1, '{ST_OK,        32'sh7fffffff,    7'd4,  7'd4}},
    '{OP_SEARCH, -32'sd1,          8'd1,  1'b1, '{ST_OK,        -32'sd1,          7'd1,  7'd4}},
    '{OP_SEARCH, 32'sd12345,       8'd1,  1'b1, '{ST_NOT_FOUND, 32'sd0,           7'd0,  7'd4}},
    '{OP_UNUSED, 32'sh7fffffff,    8'd1,  1'b1, '{ST_OK,        32'sd0,           7'd0,  7'd4}},
    '{OP_POP,    32'sd0,           8'd1,  1'b1, '{ST_OK,        -32'sd1,          7'd0,  7'd3}},
    '{OP_PUSH,   32'sd0,           8'd1,  1'b1, '{ST_OK,        32'sd0,           7'd0,  7'd4}},
    '{OP_SEARCH, 32'sd0,           8'd1,  1'b1, '{ST_OK,        32'sd0,           7'd1,  7'd4}},
    '{OP_PUSH,   32'sh55555555,    8'd60, 1'b0, '0},
    '{OP_PUSH,   32'shaaaaaaaa,    8'd1,  1'b1, '{ST_OVERFLOW,  32'sd0,           7'd0,  7'd64}},
    '{OP_SEARCH, 32'shaaaaaaaa,    8'd1,  1'b1, '{ST_NOT_FOUND, 32'sd0,           7'd0,  7'd64}},
    '{OP_SEARCH, 32'sh7fffffff,    8'd1,  1'b1, '{ST_OK,        32'sh7fffffff,    7'd64, 7'd64}},
    '{OP_POP,    32'sd0,           8'd63, 1'b0, '0},
    '{OP_POP,    32'sd0,           8'd1,  1'b1, '{ST_OK,        32'sh7fffffff,    7'd0,  7'd0}},
    '{OP_POP,    32'sd0,           8'd1,  1'b1, '{ST_EMPTY,     32'sd0,           7'd0,  7'd0}},
    '{OP_SEARCH, 32'sd0,           8'd1,  1'b1, '{ST_EMPTY,     32'sd0,           7'd0,  7'd0}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = OP_PUSH;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [6:0]         position;
  logic [6:0]         level;

  logic signed [31:0] model_stack [STACK_DEPTH];
  int                 model_fill = 0;
  stack_result_t      pending_results [$];
  stack_result_t      oldest;
  int                 error_count = 0;
  bit                 quiet_stretch = 1'b0;

  bounded_stack_with_search_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .operation(operation),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .data     (data),
    .position (position),
    .level    (level)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit idle_now();
    return !quiet_stretch && ($urandom_range(0, 99) < 21);
  endfunction

  // applies one operation to the shadow stack and returns its result
  function automatic stack_result_t predict_stack_result(input logic [1:0] op,
                                                         input logic signed [31:0] val);
    stack_result_t r;
    int i;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (model_fill >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_stack[model_fill] = val;
          model_fill++;
        end
      end
      OP_POP: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          model_fill--;
          r.data = model_stack[model_fill];
        end
      end
      OP_SEARCH: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOT_FOUND;
          for (i = 0; i < model_fill; i++) begin
            if (model_stack[model_fill - 1 - i] == val) begin
              r.status = ST_OK;
              r.data = val;
              r.position = 7'(i + 1);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.level = 7'(model_fill);
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [1:0] op, input logic signed [31:0] val,
                           input bit typed, input stack_result_t typed_res);
    stack_result_t r;
    if (idle_now()) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (idle_now());
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= val;
    r = predict_stack_result(op, val);
    pending_results.push_back(typed ? typed_res : r);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 32'($signed($urandom_range(0, 15)) - 8);
    if (sel < 70) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom());
  endfunction

  function automatic logic [1:0] pick_op(input phase_t ph);
    int sel;
    int push_w;
    int pop_w;
    sel = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  begin push_w = 70; pop_w = 10; end
      PH_DRAIN: begin push_w = 10; pop_w = 70; end
      default:  begin push_w = 40; pop_w = 30; end
    endcase
    if (sel < push_w) return OP_PUSH;
    if (sel < push_w + pop_w) return OP_POP;
    if (sel < 98) return OP_SEARCH;
    return OP_UNUSED;
  endfunction

  always @(negedge clk) begin
    out_ready <= quiet_stretch ? 1'b1 : ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending");
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status);
          error_count++;
        end
        if (data !== oldest.data) begin
          $error("data: expected %0d, got %0d", oldest.data, data);
          error_count++;
        end
        if (position !== oldest.position) begin
          $error("position: expected %0d, got %0d", oldest.position, position);
          error_count++;
        end
        if (level !== oldest.level) begin
          $error("level: expected %0d, got %0d", oldest.level, level);
          error_count++;
        end
      end
    end
  end

  initial begin
    phase_t             ph;
    logic [1:0]         op;
    logic signed [31:0] val;
    int                 n;
    int                 k;
    ph = PH_MIX;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[r]) begin
      for (k = 0; k < DIRECTED[r].reps; k++) begin
        send_beat(DIRECTED[r].op, DIRECTED[r].val, DIRECTED[r].typed, DIRECTED[r].res);
      end
    end

    for (n = 0; n < RANDOM_BEATS; n++) begin
      quiet_stretch = (n >= 700) && (n < 1000);
      if (n % 100 == 0) ph = phase_t'($urandom_range(0, 2));
      op = pick_op(ph);
      // searches mostly hit an entry that is really stored, at a random depth
      if (op == OP_SEARCH && model_fill > 0 && $urandom_range(0, 99) < 60) begin
        val = model_stack[$urandom_range(0, model_fill - 1)];
      end else begin
        val = pick_value();
      end
      send_beat(op, val, 1'b0, '0);
    end
    in_valid <= 1'b0;
    quiet_stretch = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // longest walk visits every stored entry
    repeat (STACK_DEPTH + 16) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
